// ===== hdl/fkhm_pkg.sv =====
// ----------------------------------------------------------------------------
// fkhm_pkg
// shared types and constants of the four-key hash map
// ----------------------------------------------------------------------------
package fkhm_pkg;

	localparam int BUCKETS = 256;
	localparam int NODES   = 256;
	localparam int BW      = $clog2(BUCKETS);
	localparam int NW      = $clog2(NODES);
	localparam int CW      = $clog2(NODES + 1);

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EXISTS  = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HEAD,
		S_FETCH,
		S_CMP,
		S_LINK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;      // capture request, compute bucket
		logic rd_head;   // read bucket head
		logic rd_node;   // read current node
		logic step;      // advance along chain
		logic do_link;   // write new node and link
		logic set_res;   // capture result
		logic [1:0] res_status;
		logic res_value;
	} cmd_t;

	typedef struct packed {
		logic cur_valid;
		logic hit;
		logic stop;
		logic pool_full;
		logic op_search;
		logic walk_limit;
	} sts_t;

endpackage

// ===== hdl/fkhm_ctrl.sv =====
// ----------------------------------------------------------------------------
// fkhm_ctrl
// controller sequencing the chain walk of one request
// ----------------------------------------------------------------------------
module fkhm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  fkhm_pkg::sts_t  sts,
	output fkhm_pkg::cmd_t  cmd
);
	import fkhm_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.set_res)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_HEAD;
				end
			end
			S_HEAD: begin
				cmd.rd_head = 1'b1;
				state_d     = S_FETCH;
			end
			S_FETCH: begin
				if (sts.cur_valid && !sts.walk_limit) begin
					cmd.rd_node = 1'b1;
					state_d     = S_CMP;
				end else begin
					state_d = S_LINK;
				end
			end
			S_CMP: begin
				if (sts.hit || sts.stop) begin
					state_d = S_LINK;
				end else begin
					cmd.step = 1'b1;
					state_d  = S_FETCH;
				end
			end
			S_LINK: begin
				if (!out_valid_q || out_ready) begin
					cmd.set_res = 1'b1;
					state_d     = S_DONE;
					if (sts.op_search) begin
						cmd.res_status = sts.hit ? ST_OK : ST_MISSING;
						cmd.res_value  = sts.hit;
					end else if (sts.hit) begin
						cmd.res_status = ST_EXISTS;
					end else if (sts.pool_full) begin
						cmd.res_status = ST_FULL;
					end else begin
						cmd.res_status = ST_OK;
						cmd.do_link    = 1'b1;
					end
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_link |-> !sts.op_search && !sts.hit && !sts.pool_full)
		else $error("link on bad condition");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_res |-> !out_valid_q || out_ready)
		else $error("result overwritten");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_HEAD)
		else $error("load did not start walk");

endmodule

// ===== hdl/fkhm_dp.sv =====
// ----------------------------------------------------------------------------
// fkhm_dp
// datapath: bucket heads, node pool memories, key compare and linking
// ----------------------------------------------------------------------------
module fkhm_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  fkhm_pkg::cmd_t  cmd,
	output fkhm_pkg::sts_t  sts,
	input  logic [7:0]      bucket_mask,
	input  logic            operation,
	input  logic [31:0]     key_first,
	input  logic [31:0]     key_second,
	input  logic [31:0]     key_third,
	input  logic [31:0]     key_fourth,
	input  logic [31:0]     value_in,
	output logic [1:0]      status,
	output logic [31:0]     value_out
);
	import fkhm_pkg::*;

	logic [BUCKETS-1:0] head_vld_q;
	logic [NW-1:0]      head_mem [BUCKETS];
	logic [63:0]        khi_mem  [NODES];
	logic [63:0]        klo_mem  [NODES];
	logic [31:0]        val_mem  [NODES];
	logic [NW:0]        link_mem [NODES];   // valid bit above index

	logic [CW-1:0]  count_q;
	logic           op_q;
	logic [31:0]    k1_q, k2_q, k3_q, k4_q, vin_q;
	logic [BW-1:0]  bkt_q;
	logic           cur_vld_q;
	logic [NW-1:0]  cur_q;
	logic           prev_vld_q;
	logic [NW-1:0]  prev_q;
	logic [CW-1:0]  steps_q;
	logic [63:0]    rd_khi_q, rd_klo_q;
	logic [31:0]    rd_val_q;
	logic [NW:0]    rd_link_q;
	logic [NW:0]    prev_link_q;
	logic [NW:0]    head_word_q;
	logic [1:0]     status_q;
	logic [31:0]    value_q;

	logic [33:0]    sum;
	logic [NW-1:0]  new_idx;
	logic           eq1, eq_rest, lt_rest;

	assign sum = {2'b0, key_first} + {2'b0, key_second} + {2'b0, key_third}
		+ {2'b0, key_fourth};
	assign new_idx = count_q[NW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= '0;
			count_q    <= '0;
		end else if (cmd.do_link) begin
			count_q <= count_q + 1'b1;
			if (!prev_vld_q)
				head_vld_q[bkt_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			k1_q  <= key_first;
			k2_q  <= key_second;
			k3_q  <= key_third;
			k4_q  <= key_fourth;
			vin_q <= value_in;
			bkt_q <= BW'(sum[33:2] & {24'b0, bucket_mask});
			prev_vld_q <= 1'b0;
			steps_q    <= '0;
		end
		if (cmd.rd_head) begin
			cur_vld_q   <= head_vld_q[bkt_q];
			cur_q       <= head_mem[bkt_q];
			head_word_q <= {head_vld_q[bkt_q], head_mem[bkt_q]};
		end
		if (cmd.rd_node) begin
			rd_khi_q  <= khi_mem[cur_q];
			rd_klo_q  <= klo_mem[cur_q];
			rd_val_q  <= val_mem[cur_q];
			rd_link_q <= link_mem[cur_q];
			steps_q   <= steps_q + 1'b1;
		end
		if (cmd.step) begin
			prev_vld_q  <= 1'b1;
			prev_q      <= cur_q;
			prev_link_q <= rd_link_q;
			cur_vld_q   <= rd_link_q[NW];
			cur_q       <= rd_link_q[NW-1:0];
		end
		if (cmd.do_link) begin
			khi_mem[new_idx] <= {k1_q, k2_q};
			klo_mem[new_idx] <= {k3_q, k4_q};
			val_mem[new_idx] <= vin_q;
			if (prev_vld_q) begin
				link_mem[new_idx] <= prev_link_q;
				link_mem[prev_q]  <= {1'b1, new_idx};
			end else begin
				link_mem[new_idx] <= head_word_q;
				head_mem[bkt_q]   <= new_idx;
			end
		end
		if (cmd.set_res) begin
			status_q <= cmd.res_status;
			value_q  <= cmd.res_value ? rd_val_q : 32'd0;
		end
	end

	assign eq1     = (rd_khi_q[63:32] == k1_q);
	assign eq_rest = (rd_khi_q[31:0] == k2_q) && (rd_klo_q == {k3_q, k4_q});
	assign lt_rest = ({k2_q, k3_q, k4_q} < {rd_khi_q[31:0], rd_klo_q});

	always_comb begin
		sts            = '0;
		sts.cur_valid  = cur_vld_q;
		sts.walk_limit = (steps_q == CW'(NODES));
		sts.hit        = eq1 && eq_rest && cmd.rd_node == 1'b0 && steps_q != '0
			&& cur_vld_q;
		sts.stop       = eq1 && lt_rest && steps_q != '0 && cur_vld_q;
		sts.pool_full  = (count_q == CW'(NODES));
		sts.op_search  = (op_q == OP_SEARCH);
	end

	assign status    = status_q;
	assign value_out = value_q;

endmodule

// ===== hdl/four_key_hash_map.sv =====
// ----------------------------------------------------------------------------
// four_key_hash_map
// hash map keyed by four 32-bit words, chained buckets in a node pool
// ----------------------------------------------------------------------------
// channel  direction  handshake
// in       request    in_valid / in_ready
// out      result     out_valid / out_ready
// cfg      apb        psel penable pwrite
// a request reads the bucket head, then reads and compares chain nodes in turn
// until a match, the ordering point or the end of the chain
// reset empties all buckets and the pool; no clearing pass
// a stalled result holds the walk of the next request before its final step
// ----------------------------------------------------------------------------
module four_key_hash_map (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [31:0] key_first,
	input  logic [31:0] key_second,
	input  logic [31:0] key_third,
	input  logic [31:0] key_fourth,
	input  logic [31:0] value_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] value_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import fkhm_pkg::*;

	cmd_t       cmd;
	sts_t       sts;
	logic [7:0] mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mask_q <= 8'hff;
		else if (psel && penable && pwrite && paddr == 2'd0)
			mask_q <= pwdata[7:0];
	end

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {24'd0, mask_q} : 32'd0;

	fkhm_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
	);

	fkhm_dp u_dp (
		.clk, .arst_n, .cmd, .sts, .bucket_mask(mask_q), .operation,
		.key_first, .key_second, .key_third, .key_fourth, .value_in,
		.status, .value_out
	);

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the four-key hash map: directed and random
// insert and search requests under several bucket masks, with random idling
// on both channels and a long result stall that fills the block, checked
// against an in-bench copy of the map
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fkhm_pkg::*;

	typedef struct {
		logic        op;
		logic [31:0] k1, k2, k3, k4;
		logic [31:0] val;
	} req_t;

	typedef struct {
		logic [1:0]  st;
		logic [31:0] val;
	} res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        operation = OP_INSERT;
	logic [31:0] key_first = '0, key_second = '0, key_third = '0, key_fourth = '0;
	logic [31:0] value_in = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [31:0] value_out;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// map copy
	logic [7:0]  mask_q = 8'd255;
	logic        head_ok [BUCKETS];
	logic [7:0]  head_ix [BUCKETS];
	logic [31:0] nk1 [NODES], nk2 [NODES], nk3 [NODES], nk4 [NODES];
	logic [31:0] nval [NODES];
	logic        lnk_ok [NODES];
	logic [7:0]  lnk_ix [NODES];
	int          used_nodes = 0;

	req_t pending_reqs [$];
	res_t expected_results [$];
	req_t known_keys [$];
	int   errors = 0;
	int   results_seen = 0;
	int   gap = 0;
	bit   no_idle = 1'b0;
	int   rd_wait = 0;
	int   hold_off = 0;

	four_key_hash_map u_dut (.*);

	always #10 clk = ~clk;

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want,
			results_seen);
		errors++;
	endtask

	function automatic void map_request(req_t r);
		logic [33:0] sum;
		logic [7:0]  b, cur, hit, prv;
		logic        ok, found, has_prev, stop;
		res_t        res;
		int          steps;
		sum = {2'b0, r.k1} + r.k2 + r.k3 + r.k4;
		b = sum[9:2] & mask_q;
		ok = head_ok[b];
		cur = head_ix[b];
		found = 1'b0;
		has_prev = 1'b0;
		stop = 1'b0;
		prv = '0;
		hit = '0;
		steps = 0;
		while (ok && !stop && steps < NODES) begin
			if (nk1[cur] == r.k1) begin
				if ({nk2[cur], nk3[cur], nk4[cur]} == {r.k2, r.k3, r.k4}) begin
					found = 1'b1;
					hit = cur;
					stop = 1'b1;
				end else if ({r.k2, r.k3, r.k4} < {nk2[cur], nk3[cur], nk4[cur]}) begin
					stop = 1'b1;
				end
			end
			if (!stop) begin
				has_prev = 1'b1;
				prv = cur;
				ok = lnk_ok[cur];
				cur = lnk_ix[cur];
				steps++;
			end
		end
		res.val = '0;
		if (r.op == OP_SEARCH) begin
			res.st = found ? ST_OK : ST_MISSING;
			if (found) res.val = nval[hit];
		end else if (found) begin
			res.st = ST_EXISTS;
		end else if (used_nodes >= NODES) begin
			res.st = ST_FULL;
		end else begin
			nk1[used_nodes] = r.k1;
			nk2[used_nodes] = r.k2;
			nk3[used_nodes] = r.k3;
			nk4[used_nodes] = r.k4;
			nval[used_nodes] = r.val;
			if (has_prev) begin
				lnk_ok[used_nodes] = lnk_ok[prv];
				lnk_ix[used_nodes] = lnk_ix[prv];
				lnk_ok[prv] = 1'b1;
				lnk_ix[prv] = used_nodes[7:0];
			end else begin
				lnk_ok[used_nodes] = head_ok[b];
				lnk_ix[used_nodes] = head_ix[b];
				head_ok[b] = 1'b1;
				head_ix[b] = used_nodes[7:0];
			end
			used_nodes++;
			res.st = ST_OK;
		end
		expected_results.push_back(res);
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		req_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap <= 0;
		end else begin
			if (in_valid && in_ready)
				map_request('{operation, key_first, key_second, key_third, key_fourth,
					value_in});
			if (!in_valid || in_ready) begin
				if (gap > 0) begin
					gap <= gap - 1;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					r = pending_reqs.pop_front();
					operation <= r.op;
					key_first <= r.k1;
					key_second <= r.k2;
					key_third <= r.k3;
					key_fourth <= r.k4;
					value_in <= r.val;
					in_valid <= 1'b1;
					gap <= no_idle ? 0 : $urandom_range(0, 9);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		res_t e;
		int   w;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rd_wait <= 0;
			hold_off <= 0;
		end else begin
			w = 0;
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report("unexpected result", {30'd0, status}, 32'd0);
				end else begin
					e = expected_results.pop_front();
					if (status !== e.st) report("status", {30'd0, status}, {30'd0, e.st});
					if (value_out !== e.val) report("value_out", value_out, e.val);
				end
				results_seen++;
				w = no_idle ? 0 : $urandom_range(0, 9);
			end
			if (out_valid && out_ready && (results_seen == 60 || results_seen == 900)) begin
				hold_off <= 400;
				out_ready <= 1'b0;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ready <= 1'b0;
			end else if (w > 0) begin
				rd_wait <= w - 1;
				out_ready <= 1'b0;
			end else if (rd_wait > 0) begin
				rd_wait <= rd_wait - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic req_t mk(logic op, logic [31:0] a, b, c, d, v);
		req_t r;
		r.op = op; r.k1 = a; r.k2 = b; r.k3 = c; r.k4 = d; r.val = v;
		return r;
	endfunction

	function automatic req_t rand_req();
		req_t r;
		int   pick;
		r.op = ($urandom_range(0, 99) < 45) ? OP_INSERT : OP_SEARCH;
		r.val = $urandom;
		pick = $urandom_range(0, 9);
		if (pick < 4 && known_keys.size() > 0) begin
			r = known_keys[$urandom_range(0, known_keys.size() - 1)];
			r.op = ($urandom_range(0, 99) < 45) ? OP_INSERT : OP_SEARCH;
			r.val = $urandom;
		end else if (pick < 7) begin
			r.k1 = $urandom_range(0, 3);
			r.k2 = $urandom_range(0, 7);
			r.k3 = $urandom_range(0, 7);
			r.k4 = $urandom_range(0, 7);
		end else begin
			r.k1 = $urandom;
			r.k2 = $urandom;
			r.k3 = $urandom;
			r.k4 = $urandom;
		end
		if (r.op == OP_INSERT) known_keys.push_back(r);
		return r;
	endfunction

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_mask(logic [7:0] m);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 2'd0;
		pwdata <= {24'd0, m};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		mask_q = m;
		@(posedge clk);
		if (prdata !== {24'd0, m}) report("prdata", prdata, {24'd0, m});
		if (pready !== 1'b1) report("pready", {31'd0, pready}, 32'd1);
	endtask

	task automatic run_random(int n, logic [7:0] m);
		wait_idle();
		set_mask(m);
		for (int i = 0; i < n; i++) begin
			if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
			pending_reqs.push_back(rand_req());
		end
	endtask

	initial begin
		for (int i = 0; i < BUCKETS; i++) begin
			head_ok[i] = 1'b0;
			head_ix[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// extremes, key sum overflow, duplicates, ordering inside one bucket
		pending_reqs.push_back(mk(OP_SEARCH, 0, 0, 0, 0, 32'hffffffff));
		pending_reqs.push_back(mk(OP_INSERT, 0, 0, 0, 0, 32'hffffffff));
		pending_reqs.push_back(mk(OP_SEARCH, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk(OP_INSERT, 0, 0, 0, 0, 32'h1234));
		pending_reqs.push_back(mk(OP_INSERT, '1, '1, '1, '1, 0));
		pending_reqs.push_back(mk(OP_SEARCH, '1, '1, '1, '1, 0));
		pending_reqs.push_back(mk(OP_SEARCH, '1, '1, '1, 32'hfffffffe, 0));
		pending_reqs.push_back(mk(OP_INSERT, 5, 2, 0, 0, 32'ha));
		pending_reqs.push_back(mk(OP_INSERT, 5, 1, 0, 1, 32'hb));
		pending_reqs.push_back(mk(OP_INSERT, 5, 0, 2, 0, 32'hc));
		pending_reqs.push_back(mk(OP_INSERT, 5, 0, 1, 1, 32'hd));
		pending_reqs.push_back(mk(OP_INSERT, 5, 0, 0, 2, 32'he));
		pending_reqs.push_back(mk(OP_INSERT, 4, 3, 0, 0, 32'hf));
		pending_reqs.push_back(mk(OP_INSERT, 6, 1, 0, 0, 32'h10));
		pending_reqs.push_back(mk(OP_SEARCH, 5, 2, 0, 0, 0));
		pending_reqs.push_back(mk(OP_SEARCH, 5, 0, 1, 1, 0));
		pending_reqs.push_back(mk(OP_SEARCH, 5, 0, 0, 2, 0));
		pending_reqs.push_back(mk(OP_SEARCH, 4, 3, 0, 0, 0));
		pending_reqs.push_back(mk(OP_SEARCH, 5, 1, 1, 0, 0));
		pending_reqs.push_back(mk(OP_INSERT, 5, 1, 0, 1, 32'h99));
		pending_reqs.push_back(mk(OP_SEARCH, 5, 1, 0, 1, 0));

		run_random(350, 8'd255);
		run_random(250, 8'd0);
		run_random(500, 8'd3);
		run_random(250, 8'd170);
		run_random(280, 8'd255);

		wait_idle();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#200ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
